// ===== sv/rvfa_pkg.sv =====
// shared types and constants for the rtp video frame assembler
`timescale 1ns / 1ps

package rvfa_pkg;

    localparam int MAX_UNITS_PER_PACKET = 15;
    localparam int MAX_UNITS_PER_FRAME  = 255;
    localparam int UNIT_LIMIT = (MAX_UNITS_PER_FRAME > 255) ? 255 : MAX_UNITS_PER_FRAME;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 6;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 4;

    // flag bit positions: key, sps, pps, idr
    localparam int FLAG_KEY = 0;
    localparam int FLAG_SPS = 1;
    localparam int FLAG_PPS = 2;
    localparam int FLAG_IDR = 3;

    typedef struct packed {
        logic [31:0] ssrc;
        logic [31:0] timestamp;
        logic [15:0] seq;
        logic [15:0] seq_m1;
        logic        marker;
        logic [3:0]  flags;
        logic [3:0]  units;
    } pkt_t;

    typedef struct packed {
        logic [31:0] ssrc;
        logic [31:0] timestamp;
        logic [15:0] start_seq;
        logic [15:0] stop_seq;
        logic [3:0]  flags;
        logic [7:0]  units;
    } frm_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_CW-1:0] level;
    } fifo_stat_t;

endpackage

// ===== sv/rtp_video_frame_assembler.sv =====
// top level of the rtp video frame assembler
`timescale 1ns / 1ps

// Groups parsed RTP video packet descriptors into frames and sends one word per
// completed frame. One input word can be taken every cycle while the front
// register is empty or the queue has room. An accepted word is held in the front
// register, written into a four-entry queue and applied to the open frame when
// the back end pops it; a closing word's frame is offered from the output
// register. Invalid or malformed packets are dropped in the front; a timestamp or
// ssrc change discards the open frame silently, and a frame with a sequence gap or
// no units is not sent. The back end takes a queued word only while its output
// register is free or being read, so with the master side stalled the input keeps
// flowing until the queue and the front register hold five words.
module rtp_video_frame_assembler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ssrc[31:0], timestamp[63:32], seq[79:64], units[83:80], zero pad
    input  logic [rvfa_pkg::S_DATA_W-1:0] s_tdata,
    // valid, malformed, key, sps, pps, idr
    input  logic [rvfa_pkg::S_USER_W-1:0] s_tuser,
    // marker bit
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ssrc, timestamp, start_seq, stop_seq, units
    output logic [rvfa_pkg::M_DATA_W-1:0] m_tdata,
    // key, sps, pps, idr
    output logic [rvfa_pkg::M_USER_W-1:0] m_tuser
);
    import rvfa_pkg::*;

    fifo_stat_t q_stat;
    logic       q_push;
    logic       q_pop;
    pkt_t       q_in;
    pkt_t       q_head;
    frm_t       frm;

    rvfa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_pkt    (q_in)
    );

    rvfa_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_pkt (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    rvfa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_frm   (frm)
    );

    assign m_tdata = {frm.units, frm.stop_seq, frm.start_seq, frm.timestamp, frm.ssrc};
    assign m_tuser = frm.flags;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue level beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_units_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (frm.units != '0))
        else $error("frame sent with zero units");

endmodule

// ===== sv/rvfa_front.sv =====
// front stage: takes input words, drops unusable packets, prepares descriptors
`timescale 1ns / 1ps

module rvfa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rvfa_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [rvfa_pkg::S_USER_W-1:0] s_tuser,
    input  logic                          s_tlast,
    input  rvfa_pkg::fifo_stat_t          q_stat,
    output logic                          q_push,
    output rvfa_pkg::pkt_t                q_pkt
);
    import rvfa_pkg::*;

    logic       fr_valid_reg;
    logic       fr_valid_next;
    pkt_t       fr_pkt_reg;
    pkt_t       pkt_w;
    logic       accept;
    logic       usable;
    logic [3:0] units_raw;

    assign s_tready = !fr_valid_reg || !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign usable   = s_tuser[0] && !s_tuser[1];
    assign q_push   = fr_valid_reg && !q_stat.full;
    assign q_pkt    = fr_pkt_reg;

    always_comb
    begin
        units_raw       = s_tdata[83:80];
        pkt_w.ssrc      = s_tdata[31:0];
        pkt_w.timestamp = s_tdata[63:32];
        pkt_w.seq       = s_tdata[79:64];
        // predecessor number, so the back end only compares against prev seq
        pkt_w.seq_m1    = s_tdata[79:64] - 16'd1;
        pkt_w.marker    = s_tlast;
        pkt_w.flags     = s_tuser[5:2];
        if ({4'd0, units_raw} > 8'(MAX_UNITS_PER_PACKET))
            pkt_w.units = 4'(MAX_UNITS_PER_PACKET);
        else
            pkt_w.units = units_raw;
    end

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
            fr_valid_next = usable;
        else if (q_push)
            fr_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else
            fr_valid_reg <= fr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && usable)
            fr_pkt_reg <= pkt_w;
    end

endmodule

// ===== sv/rvfa_fifo.sv =====
// short descriptor queue between front and back
`timescale 1ns / 1ps

module rvfa_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rvfa_pkg::pkt_t       push_pkt,
    input  logic                 pop,
    output rvfa_pkg::pkt_t       head,
    output rvfa_pkg::fifo_stat_t stat
);
    import rvfa_pkg::*;

    pkt_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.level = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_pkt;
    end

endmodule

// ===== sv/rvfa_back.sv =====
// back stage: open frame tracking and the frame output register
`timescale 1ns / 1ps

module rvfa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rvfa_pkg::pkt_t       q_head,
    input  rvfa_pkg::fifo_stat_t q_stat,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rvfa_pkg::frm_t       m_frm
);
    import rvfa_pkg::*;

    logic        open_reg;
    logic        open_next;
    logic        gap_reg;
    logic        gap_next;
    logic [15:0] prev_seq_reg;
    logic [31:0] ssrc_reg;
    logic [31:0] ts_reg;
    logic [15:0] start_seq_reg;
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;
    logic [7:0]  total_reg;
    logic [7:0]  total_next;
    logic [8:0]  sum;
    logic        start;
    logic        emit;
    logic        out_valid_reg;
    logic        out_valid_next;
    frm_t        out_reg;

    assign q_pop   = !q_stat.empty && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_frm   = out_reg;

    always_comb
    begin
        // a new frame opens when none is open or the stream identity changed
        start = !open_reg || (q_head.timestamp != ts_reg) || (q_head.ssrc != ssrc_reg);
        if (start)
        begin
            gap_next   = 1'b0;
            flags_next = q_head.flags;
            sum        = {5'd0, q_head.units};
        end
        else
        begin
            gap_next   = gap_reg || (prev_seq_reg != q_head.seq_m1);
            flags_next = flags_reg | q_head.flags;
            sum        = {1'b0, total_reg} + {5'd0, q_head.units};
        end
        total_next = (sum > 9'(UNIT_LIMIT)) ? 8'(UNIT_LIMIT) : sum[7:0];
        open_next  = !q_head.marker;
        emit       = q_head.marker && !gap_next && (total_next != '0);

        out_valid_next = out_valid_reg;
        if (q_pop)
            out_valid_next = emit;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                open_reg <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            gap_reg      <= gap_next;
            flags_reg    <= flags_next;
            total_reg    <= total_next;
            prev_seq_reg <= q_head.seq;
            if (start)
            begin
                ssrc_reg      <= q_head.ssrc;
                ts_reg        <= q_head.timestamp;
                start_seq_reg <= q_head.seq;
            end
            if (emit)
            begin
                out_reg.ssrc      <= start ? q_head.ssrc : ssrc_reg;
                out_reg.timestamp <= start ? q_head.timestamp : ts_reg;
                out_reg.start_seq <= start ? q_head.seq : start_seq_reg;
                out_reg.stop_seq  <= q_head.seq;
                out_reg.flags     <= flags_next;
                out_reg.units     <= total_next;
            end
        end
    end

endmodule
